FILE: hdl/gtht_pkg.sv
// ----------------------------------------------------------------------------
// Generation-tagged handle table package
// Shared constants, codes and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gtht_pkg;

	localparam int INDEX_BITS  = 4;
	localparam int HANDLE_BITS = 31;
	localparam int GEN_BITS    = HANDLE_BITS - INDEX_BITS;
	localparam int SLOT_COUNT  = 1 << INDEX_BITS;

	localparam int MODE_BITS   = 2;
	localparam int KIND_BITS   = 2;
	localparam int OWNER_BITS  = 2;
	localparam int STATUS_BITS = 2;

	localparam int IN_BITS        = MODE_BITS + HANDLE_BITS + KIND_BITS + OWNER_BITS;
	localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS       = STATUS_BITS + HANDLE_BITS + KIND_BITS;
	localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	typedef logic [INDEX_BITS-1:0]  idx_t;
	typedef logic [GEN_BITS-1:0]    gen_t;
	typedef logic [HANDLE_BITS-1:0] handle_t;
	typedef logic [KIND_BITS-1:0]   kind_t;
	typedef logic [OWNER_BITS-1:0]  owner_t;
	typedef logic [MODE_BITS-1:0]   mode_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	localparam gen_t GEN_MAX   = {GEN_BITS{1'b1}};
	localparam gen_t GEN_LAST  = GEN_MAX - gen_t'(1);
	localparam gen_t GEN_FIRST = gen_t'(1);

	localparam mode_t MODE_ALLOC    = 2'd0;
	localparam mode_t MODE_LOOKUP   = 2'd1;
	localparam mode_t MODE_FREE     = 2'd2;
	localparam mode_t MODE_FREE_ALL = 2'd3;

	localparam kind_t KIND_FREE = 2'd0;
	localparam kind_t KIND_FILE = 2'd1;
	localparam kind_t KIND_DIR  = 2'd2;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_BAD  = 2'd1;
	localparam status_t ST_FULL = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

FILE: hdl/generation_tagged_handle_table.sv
// An accepted input beat is captured in the input registers and executed once the result
// register is free; the result beat is registered. One item is handled at a time: the execute
// step reads and updates the flop-based slot table, and input is taken only between items.
// A waiting result holds the next item in execution, and the input stays stalled until then.
// Reset frees every slot, sets the generation counter to one and drops any result.
// ----------------------------------------------------------------------------
// Generation-tagged handle table
// Allocates, checks and releases generation-tagged handles over a table of
// slots, one operation per input beat and one result beat per operation.
// ----------------------------------------------------------------------------
module generation_tagged_handle_table (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// mode, handle_in, kind, owner_mask, zero fill
	input  logic [gtht_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// status, handle_out, entry_kind, zero fill
	output logic [gtht_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);

	gtht_pkg::cmd_t cmd;
	gtht_pkg::sts_t sts;

	gtht_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	gtht_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	a_exec_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !(m_axis_tvalid && !m_axis_tready))
		else $error("Result overwritten before it was taken.");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("Input accepted while an item is in progress.");

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> m_axis_tvalid)
		else $error("Executed item produced no result beat.");

	a_handle_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[gtht_pkg::STATUS_BITS-1:0] != gtht_pkg::ST_OK)
		|-> (m_axis_tdata[gtht_pkg::STATUS_BITS+gtht_pkg::HANDLE_BITS-1:
			gtht_pkg::STATUS_BITS] == '0))
		else $error("Nonzero handle on a failed operation.");
`endif

endmodule

FILE: hdl/gtht_ctrl.sv
// ----------------------------------------------------------------------------
// Generation-tagged handle table controller
// Two-state sequencer: takes one beat, then runs it through the datapath
// once the result register is free.
// ----------------------------------------------------------------------------
module gtht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  gtht_pkg::sts_t sts,
	output gtht_pkg::cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cmd.load      = s_axis_tvalid && (state_q == ST_IDLE);
	assign cmd.exec      = (state_q == ST_EXEC) && !sts.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (cmd.exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/gtht_dp.sv
// ----------------------------------------------------------------------------
// Generation-tagged handle table datapath
// Slot table in flops, lowest-free-slot encoder, generation counter,
// handle check and the registered result beat.
// ----------------------------------------------------------------------------
module gtht_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  gtht_pkg::cmd_t                       cmd,
	output gtht_pkg::sts_t                       sts,
	// mode, handle_in, kind, owner_mask, zero fill
	input  logic [gtht_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// status, handle_out, entry_kind, zero fill
	output logic [gtht_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);

	localparam int H_LSB = gtht_pkg::MODE_BITS;
	localparam int K_LSB = H_LSB + gtht_pkg::HANDLE_BITS;
	localparam int O_LSB = K_LSB + gtht_pkg::KIND_BITS;

	gtht_pkg::mode_t   mode_q;
	gtht_pkg::handle_t handle_q;
	gtht_pkg::kind_t   kind_in_q;
	gtht_pkg::owner_t  owner_in_q;

	gtht_pkg::kind_t  slot_kind_q  [gtht_pkg::SLOT_COUNT];
	gtht_pkg::gen_t   slot_gen_q   [gtht_pkg::SLOT_COUNT];
	gtht_pkg::owner_t slot_owner_q [gtht_pkg::SLOT_COUNT];
	gtht_pkg::gen_t   gen_ctr_q;

	logic              out_valid_q;
	gtht_pkg::status_t out_status_q;
	gtht_pkg::handle_t out_handle_q;
	gtht_pkg::kind_t   out_kind_q;

	gtht_pkg::idx_t    idx;
	gtht_pkg::gen_t    gen_in;
	gtht_pkg::kind_t   sel_kind;
	logic              live;
	logic              free_found;
	gtht_pkg::idx_t    free_idx;
	gtht_pkg::gen_t    gen_next;
	logic              do_alloc;
	logic              do_free;
	logic              do_free_all;
	gtht_pkg::status_t res_status;
	gtht_pkg::handle_t res_handle;
	gtht_pkg::kind_t   res_kind;

	assign sts.out_busy = out_valid_q && !m_axis_tready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= s_axis_tdata[H_LSB-1:0];
			handle_q   <= s_axis_tdata[K_LSB-1:H_LSB];
			kind_in_q  <= s_axis_tdata[O_LSB-1:K_LSB];
			owner_in_q <= s_axis_tdata[O_LSB+gtht_pkg::OWNER_BITS-1:O_LSB];
		end
	end

	assign idx      = handle_q[gtht_pkg::INDEX_BITS-1:0];
	assign gen_in   = handle_q[gtht_pkg::HANDLE_BITS-1:gtht_pkg::INDEX_BITS];
	assign sel_kind = slot_kind_q[idx];
	assign live     = (gen_in != gtht_pkg::GEN_MAX) && (sel_kind != gtht_pkg::KIND_FREE)
		&& (slot_gen_q[idx] == gen_in);
	assign gen_next = (gen_ctr_q == gtht_pkg::GEN_LAST) ? gtht_pkg::GEN_FIRST
		: gen_ctr_q + gtht_pkg::gen_t'(1);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = gtht_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
			if (slot_kind_q[i] == gtht_pkg::KIND_FREE) begin
				free_found = 1'b1;
				free_idx   = gtht_pkg::idx_t'(i);
			end
		end
	end

	always_comb begin
		res_status  = gtht_pkg::ST_OK;
		res_handle  = '0;
		res_kind    = gtht_pkg::KIND_FREE;
		do_alloc    = 1'b0;
		do_free     = 1'b0;
		do_free_all = 1'b0;
		case (mode_q)
			gtht_pkg::MODE_ALLOC: begin
				if (kind_in_q != gtht_pkg::KIND_FILE && kind_in_q != gtht_pkg::KIND_DIR) begin
					res_status = gtht_pkg::ST_BAD;
				end else if (!free_found) begin
					res_status = gtht_pkg::ST_FULL;
				end else begin
					do_alloc   = cmd.exec;
					res_handle = {gen_ctr_q, free_idx};
				end
			end
			gtht_pkg::MODE_LOOKUP: begin
				if (live && (kind_in_q == gtht_pkg::KIND_FREE || kind_in_q == sel_kind)) begin
					res_kind = sel_kind;
				end else begin
					res_status = gtht_pkg::ST_BAD;
				end
			end
			gtht_pkg::MODE_FREE: begin
				if (live) begin
					res_kind = sel_kind;
					do_free  = cmd.exec;
				end else begin
					res_status = gtht_pkg::ST_BAD;
				end
			end
			default: begin
				do_free_all = cmd.exec;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < gtht_pkg::SLOT_COUNT; i++) begin
				slot_kind_q[i] <= gtht_pkg::KIND_FREE;
			end
			gen_ctr_q <= gtht_pkg::GEN_FIRST;
		end else begin
			for (int i = 0; i < gtht_pkg::SLOT_COUNT; i++) begin
				if (do_free_all && ((slot_owner_q[i] & owner_in_q) != '0)) begin
					slot_kind_q[i] <= gtht_pkg::KIND_FREE;
				end
			end
			if (do_free) begin
				slot_kind_q[idx] <= gtht_pkg::KIND_FREE;
			end
			if (do_alloc) begin
				slot_kind_q[free_idx] <= kind_in_q;
				gen_ctr_q             <= gen_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_alloc) begin
			slot_gen_q[free_idx]   <= gen_ctr_q;
			slot_owner_q[free_idx] <= owner_in_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_status_q <= res_status;
			out_handle_q <= res_handle;
			out_kind_q   <= res_kind;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(gtht_pkg::OUT_TDATA_BITS - gtht_pkg::OUT_BITS){1'b0}},
		out_kind_q, out_handle_q, out_status_q};

endmodule
